FILE: src/leb128_pkg.sv
// Shared types and constants for the LEB128 varint decoder.
// Holds the transfer payload structs and status codes; no dependencies.
package leb128_pkg;

  // Payload bits carried by one stream byte
  localparam int unsigned STEP_BITS  = 7;
  // Width of the running shift (holds up to 64 + 7)
  localparam int unsigned SHIFT_W    = 7;
  // Width of the consumed-byte counter
  localparam int unsigned COUNT_W    = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
    logic       signed_mode;
  } leb128_in_t;

  typedef struct packed {
    logic [63:0]        value_bits;
    logic [1:0]         status;
    logic [COUNT_W-1:0] byte_count;
  } leb128_out_t;

endpackage

FILE: src/leb128_dec.sv
// Per-byte LEB128 decode step: running value state plus the single-pass
// next-state and result logic. Depends on leb128_pkg.
module leb128_dec #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  leb128_pkg::leb128_in_t step_data,
  output logic                   res_valid,
  output leb128_pkg::leb128_out_t res_data
);
  import leb128_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES_W    = '1;
  localparam logic [63:0]          HIGH_FILL = ~({64{1'b1}} >> (64 - WORD_BITS));
  localparam logic [7:0]           WB8       = 8'(WORD_BITS);

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [SHIFT_W-1:0]   shift_r, shift_nxt;
  logic                 busy_r, busy_nxt;
  logic                 signed_r, signed_nxt;
  logic [COUNT_W-1:0]   bytes_r, bytes_nxt;

  logic                 start;
  logic                 lsigned;
  logic [WORD_BITS-1:0] acc_cur;
  logic [SHIFT_W-1:0]   sh;
  logic [COUNT_W-1:0]   cnt, cnt_inc;
  logic [6:0]           payload;
  logic [7:0]           need, room, pos, sh_step;
  logic                 full, part_lost, lost, fill_err, shift_err;
  logic [WORD_BITS-1:0] acc_new, val_w;
  logic [63:0]          val_64;

  // Operands: a new value starts from a cleared state
  always_comb begin
    start   = !busy_r;
    lsigned = start ? step_data.signed_mode : signed_r;
    acc_cur = start ? '0 : acc_r;
    sh      = start ? '0 : shift_r;
    cnt     = start ? '0 : bytes_r;
    cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
    payload = step_data.data_byte[STEP_BITS-1:0];
  end

  // Overflow checks, accumulation and final value
  always_comb begin
    need      = 8'(sh) + 8'(lsigned);
    full      = need >= WB8;
    room      = WB8 - need;
    part_lost = !full && (room < 8'(STEP_BITS)) && ((payload >> room[2:0]) != '0);
    lost      = (payload != '0) && (full || part_lost);
    acc_new   = acc_cur | (WORD_BITS'(payload) << sh);
    pos       = 8'(sh) + 8'(STEP_BITS);
    fill_err  = lsigned && step_data.data_byte[6] && (pos >= WB8);
    sh_step   = pos;
    shift_err = sh_step > WB8;
    val_w     = acc_new;
    if (lsigned && step_data.data_byte[6]) begin
      val_w = acc_new | (ONES_W << pos);
    end
    val_64 = 64'(val_w);
    if (lsigned && val_w[WORD_BITS-1]) begin
      val_64 = val_64 | HIGH_FILL;
    end
  end

  // Result and next state
  always_comb begin
    res_valid            = 1'b0;
    res_data.value_bits  = '0;
    res_data.status      = ST_OK;
    res_data.byte_count  = cnt_inc;
    acc_nxt              = acc_r;
    shift_nxt            = shift_r;
    busy_nxt             = busy_r;
    signed_nxt           = signed_r;
    bytes_nxt            = bytes_r;
    if (step_en) begin
      if (step_data.buffer_end) begin
        res_valid           = busy_r;
        res_data.status     = ST_TRUNC;
        res_data.byte_count = bytes_r;
      end else if (lost) begin
        res_valid       = 1'b1;
        res_data.status = ST_OVERFLOW;
      end else if (!step_data.data_byte[7]) begin
        res_valid = 1'b1;
        if (fill_err) begin
          res_data.status = ST_OVERFLOW;
        end else begin
          res_data.value_bits = val_64;
        end
      end else if (shift_err) begin
        res_valid       = 1'b1;
        res_data.status = ST_OVERFLOW;
      end
      if (res_valid) begin
        acc_nxt    = '0;
        shift_nxt  = '0;
        busy_nxt   = 1'b0;
        signed_nxt = 1'b0;
        bytes_nxt  = '0;
      end else if (!step_data.buffer_end) begin
        acc_nxt    = acc_new;
        shift_nxt  = sh_step[SHIFT_W-1:0];
        busy_nxt   = 1'b1;
        signed_nxt = lsigned;
        bytes_nxt  = cnt_inc;
      end
    end
  end

  // Hold decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      shift_r  <= '0;
      busy_r   <= 1'b0;
      signed_r <= 1'b0;
      bytes_r  <= '0;
    end else begin
      acc_r    <= acc_nxt;
      shift_r  <= shift_nxt;
      busy_r   <= busy_nxt;
      signed_r <= signed_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

endmodule

FILE: src/leb128_varint_decoder_top.sv
// LEB128 varint decoder, top level: decode step plus result register and skid.
// Depends on leb128_pkg and leb128_dec.
//
// Decodes a stream of LEB128 bytes, one byte per input transfer, into 64-bit
// results, unsigned or signed (signed_mode is taken from the first byte of a
// value). A byte with bit 7 clear ends a value and yields one result; so does
// an overflow (status 2, value 0) or buffer_end while a value is open
// (status 1, value 0). buffer_end with no value open is dropped silently.
// Each byte is decoded by one shift-or stage while it waits for its transfer,
// so the block takes one byte every clock while in_stall is low. A result
// lands in the output register at the edge that transfers the byte ending its
// value if that register is free, else in the skid. A one-entry skid buffer
// behind the output register absorbs a result while out_stall is high;
// in_stall rises only when that skid entry is occupied.
module leb128_varint_decoder_top #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  leb128_pkg::leb128_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output leb128_pkg::leb128_out_t out_data
);
  import leb128_pkg::*;

  logic        in_xfer;
  logic        res_valid;
  leb128_out_t res_data;
  logic        out_valid_r;
  leb128_out_t out_data_r;
  logic        skid_valid_r;
  leb128_out_t skid_data_r;
  logic        out_free;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;

  leb128_dec #(
    .WORD_BITS (WORD_BITS)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_xfer),
    .step_data (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Advance the output register, park a result in the skid while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (res_valid) begin
      skid_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_leb128_varint_decoder_top.sv
// Self-checking testbench for leb128_varint_decoder_top.
// Drives LEB128 byte streams with random gaps and stalls and checks every decoded
// word against a local decoder model; needs only leb128_pkg and the RTL.
`timescale 1ns / 1ps

module tb_leb128_varint_decoder_top;
  import leb128_pkg::*;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTED = 40;

  // Decoder model plus the queue of decoded words still owed by the block
  class varint_tracker;
    int unsigned word_bits;
    logic [63:0] acc;
    int unsigned shift_pos;
    bit          busy;
    bit          sgn_mode;
    int unsigned nbytes;
    leb128_out_t pending_words[$];
    int unsigned errors;

    function new(int unsigned wb);
      word_bits = wb;
      errors    = 0;
      clear_state();
    endfunction

    function void clear_state();
      acc       = '0;
      shift_pos = 0;
      busy      = 1'b0;
      sgn_mode  = 1'b0;
      nbytes    = 0;
    endfunction

    function logic [63:0] word_mask();
      return {64{1'b1}} >> (64 - word_bits);
    endfunction

    // Queue one decoded word and return to idle
    function void push_word(logic [63:0] value, logic [1:0] status);
      leb128_out_t w;
      w.value_bits = value;
      w.status     = status;
      w.byte_count = COUNT_W'(nbytes);
      pending_words.push_back(w);
      clear_state();
    endfunction

    // Advance the model by one accepted byte; return 0 if the byte was ignored
    function bit note_byte(leb128_in_t item);
      logic [6:0]  payload;
      int          room;
      int unsigned pos;
      logic [63:0] value;
      if (item.buffer_end) begin
        if (!busy) return 1'b0;
        push_word('0, ST_TRUNC);
        return 1'b1;
      end
      if (!busy) begin
        clear_state();
        busy     = 1'b1;
        sgn_mode = item.signed_mode;
      end
      if (nbytes < 15) nbytes++;
      payload = item.data_byte[6:0];
      room    = int'(word_bits) - int'(shift_pos) - (sgn_mode ? 1 : 0);
      // Drop the value if any payload bit would fall off the word
      if (payload != '0) begin
        if (room <= 0 || (room < 7 && (payload >> room) != '0)) begin
          push_word('0, ST_OVERFLOW);
          return 1'b1;
        end
        acc |= (64'(payload) << shift_pos) & word_mask();
      end
      // Last byte: apply the sign fill and sign-extend to 64 bits
      if (!item.data_byte[7]) begin
        value = acc;
        if (sgn_mode) begin
          if (item.data_byte[6]) begin
            pos = shift_pos + 7;
            if (pos >= word_bits) begin
              push_word('0, ST_OVERFLOW);
              return 1'b1;
            end
            value |= word_mask() & ~((64'd1 << pos) - 64'd1);
          end
          if (value[word_bits-1]) value |= ~word_mask();
        end
        push_word(value, ST_OK);
        return 1'b1;
      end
      shift_pos += 7;
      if (shift_pos > word_bits) push_word('0, ST_OVERFLOW);
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    endtask

    // Compare one transfer from the block with the oldest owed word
    task check_word(leb128_out_t got);
      leb128_out_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d count=%0d",
                                  got.value_bits, got.status, got.byte_count));
        return;
      end
      want = pending_words.pop_front();
      if (got.value_bits !== want.value_bits)
        report_mismatch($sformatf("value_bits got %h want %h",
                                  got.value_bits, want.value_bits));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.byte_count !== want.byte_count)
        report_mismatch($sformatf("byte_count got %0d want %0d",
                                  got.byte_count, want.byte_count));
    endtask

    task finish_check();
      if (pending_words.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived",
                                  pending_words.size()));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  leb128_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  leb128_out_t out_data;

  varint_tracker tracker = new(WORD_BITS);
  bit            in_calm;
  bit            out_calm;
  int unsigned   counted;
  int unsigned   results_seen;
  int unsigned   cycles;

  always #10 clk = ~clk;

  leb128_varint_decoder_top #(
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic leb128_in_t pack_in(logic [7:0] data, logic buf_end, logic sgn);
    leb128_in_t item;
    item.data_byte   = data;
    item.buffer_end  = buf_end;
    item.signed_mode = sgn;
    return item;
  endfunction

  // Final byte of a value near the word limit: pick payloads at the boundaries
  function automatic logic [7:0] tail_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h02;
      3: return 8'h3F;
      4: return 8'h40;
      5: return 8'h7F;
      6: return 8'h7E;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // Present one byte after a random gap and hold it until the transfer
  task automatic send_item(input leb128_in_t item);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (tracker.note_byte(item)) counted++;
  endtask

  // Send one value of len bytes; near_limit biases content toward the word edge
  task automatic send_value(input bit sgn, input int unsigned len, input bit near_limit);
    logic [7:0]  b;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (near_limit) begin
        if (i + 1 == len) b = tail_byte();
        else if ($urandom_range(0, 1) == 1) b = ($urandom_range(0, 1) == 1) ? 8'h80 : 8'hFF;
      end
      b[7] = (i + 1 != len);
      send_item(pack_in(b, 1'b0, (i == 0) ? sgn : 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_directed();
    int unsigned i;
    // empty buffer while idle: no result
    send_item(pack_in(8'hA5, 1'b1, 1'b1));
    send_item(pack_in(8'h00, 1'b0, 1'b0));
    send_item(pack_in(8'h7F, 1'b0, 1'b0));
    send_item(pack_in(8'h7F, 1'b0, 1'b1));
    send_item(pack_in(8'h3F, 1'b0, 1'b1));
    // truncated after one byte
    send_item(pack_in(8'h80, 1'b0, 1'b0));
    send_item(pack_in(8'h00, 1'b1, 1'b0));
    // two-byte signed with sign fill
    send_item(pack_in(8'hC0, 1'b0, 1'b1));
    send_item(pack_in(8'h7F, 1'b0, 1'b0));
    // largest unsigned word, ten bytes
    for (i = 0; i < 9; i++) send_item(pack_in(8'hFF, 1'b0, 1'b0));
    send_item(pack_in(8'h01, 1'b0, 1'b1));
  endtask

  task automatic run_random();
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    bit          sgn;
    while (counted < ITEM_TARGET) begin
      in_calm = ((counted / 100) % 4) == 3;
      kind    = $urandom_range(0, 19);
      sgn     = 1'($urandom_range(0, 1));
      if (kind < 11) begin
        len = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(4, 10);
        send_value(sgn, len, 1'b0);
      end else if (kind < 15) begin
        send_value(sgn, $urandom_range(8, 10), 1'b1);
      end else if (kind < 16) begin
        // run past the word with continuation bytes
        send_value(sgn, 11, 1'b1);
      end else if (kind < 18) begin
        // cut a value short with buffer_end
        len = $urandom_range(1, 9);
        for (k = 0; k < len; k++)
          send_item(pack_in(8'($urandom_range(0, 255)) | 8'h80, 1'b0, sgn));
        send_item(pack_in(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
      end else begin
        repeat (8)
          send_item(pack_in(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                            1'($urandom_range(0, 1))));
      end
    end
    // close any value still open
    send_item(pack_in(8'h00, 1'b1, 1'b0));
  endtask

  // Result side: stall at random, then take one transfer and check it
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      out_calm = ((results_seen / 64) % 4) == 2;
      hold     = out_calm ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      tracker.check_word(out_data);
      results_seen++;
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    tracker.finish_check();
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: leb128_varint_decoder_top.f
src/leb128_pkg.sv
src/leb128_dec.sv
src/leb128_varint_decoder_top.sv
tb/tb_leb128_varint_decoder_top.sv
